[hdl/bptc_pkg.sv]
// shared types, constants and the compensation step sequence
package bptc_pkg;

  // field widths and clamp limits
  localparam int unsigned RawW  = 24;
  localparam int unsigned TempW = 15;
  localparam int unsigned PresW = 23;
  localparam int unsigned DiffW = 25;
  localparam int unsigned CalW  = 168;
  localparam int unsigned CfgW  = 64;
  localparam int unsigned HiW   = 40;
  localparam int unsigned IdxW  = 2;

  localparam logic signed [63:0] TempMin = -64'sd4000;
  localparam logic signed [63:0] TempMax = 64'sd8500;
  localparam logic signed [63:0] PresMax = 64'sd8388607;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegCalLo  = 2'd0;
  localparam logic [IdxW-1:0] RegCalMid = 2'd1;
  localparam logic [IdxW-1:0] RegCalHi  = 2'd2;

  // number of steps in the sequence
  localparam int unsigned NumOps = 23;
  localparam int unsigned StepW  = 5;
  localparam logic [StepW-1:0] LastStep = StepW'(NumOps - 1);

  // multiplier operand sources
  typedef enum logic [4:0] {
    SRC_D, SRC_T2S, SRC_T3, SRC_TL, SRC_Y, SRC_TSQ, SRC_TCU, SRC_RP, SRC_RP2,
    SRC_P1S, SRC_P5S, SRC_ONE, SRC_P2M, SRC_P3, SRC_P4, SRC_P6, SRC_P7, SRC_P8,
    SRC_P9, SRC_P10, SRC_P11, SRC_HUNDRED
  } src_e;

  // step result destinations
  typedef enum logic [2:0] {
    DST_TL, DST_Y, DST_TSQ, DST_TCU, DST_RP2, DST_ACC, DST_TMP
  } dst_e;

  typedef struct packed {
    src_e       a;
    src_e       b;
    logic [6:0] shift;
    dst_e       dst;
    logic       add;
  } op_t;

  // word passed from front to back
  typedef struct packed {
    logic signed [DiffW-1:0] d;
    logic [RawW-1:0]         rp;
  } work_t;

  // finished result word
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PresW-1:0]        pres;
    logic                    clip;
  } result_t;

  // step sequence: product, rounding shift, destination
  function automatic op_t op_rom(logic [StepW-1:0] idx);
    op_t o;
    o = '{a: SRC_ONE, b: SRC_ONE, shift: 7'd0, dst: DST_Y, add: 1'b0};
    case (idx)
      5'd0:  o = '{a: SRC_D,   b: SRC_T2S,     shift: 7'd0,  dst: DST_TL,  add: 1'b0};
      5'd1:  o = '{a: SRC_D,   b: SRC_D,       shift: 7'd0,  dst: DST_Y,   add: 1'b0};
      5'd2:  o = '{a: SRC_Y,   b: SRC_T3,      shift: 7'd0,  dst: DST_TL,  add: 1'b1};
      5'd3:  o = '{a: SRC_TL,  b: SRC_TL,      shift: 7'd56, dst: DST_TSQ, add: 1'b0};
      5'd4:  o = '{a: SRC_TSQ, b: SRC_TL,      shift: 7'd58, dst: DST_TCU, add: 1'b0};
      5'd5:  o = '{a: SRC_RP,  b: SRC_RP,      shift: 7'd0,  dst: DST_RP2, add: 1'b0};
      5'd6:  o = '{a: SRC_RP,  b: SRC_P1S,     shift: 7'd0,  dst: DST_ACC, add: 1'b0};
      5'd7:  o = '{a: SRC_P5S, b: SRC_ONE,     shift: 7'd0,  dst: DST_ACC, add: 1'b1};
      5'd8:  o = '{a: SRC_P6,  b: SRC_TL,      shift: 7'd22, dst: DST_ACC, add: 1'b1};
      5'd9:  o = '{a: SRC_P7,  b: SRC_TSQ,     shift: 7'd16, dst: DST_ACC, add: 1'b1};
      5'd10: o = '{a: SRC_P8,  b: SRC_TCU,     shift: 7'd13, dst: DST_ACC, add: 1'b1};
      5'd11: o = '{a: SRC_RP,  b: SRC_P2M,     shift: 7'd0,  dst: DST_Y,   add: 1'b0};
      5'd12: o = '{a: SRC_Y,   b: SRC_TL,      shift: 7'd45, dst: DST_ACC, add: 1'b1};
      5'd13: o = '{a: SRC_RP,  b: SRC_P3,      shift: 7'd0,  dst: DST_Y,   add: 1'b0};
      5'd14: o = '{a: SRC_Y,   b: SRC_TSQ,     shift: 7'd40, dst: DST_ACC, add: 1'b1};
      5'd15: o = '{a: SRC_RP,  b: SRC_P4,      shift: 7'd0,  dst: DST_Y,   add: 1'b0};
      5'd16: o = '{a: SRC_Y,   b: SRC_TCU,     shift: 7'd35, dst: DST_ACC, add: 1'b1};
      5'd17: o = '{a: SRC_RP2, b: SRC_P9,      shift: 7'd16, dst: DST_ACC, add: 1'b1};
      5'd18: o = '{a: SRC_RP2, b: SRC_P10,     shift: 7'd0,  dst: DST_Y,   add: 1'b0};
      5'd19: o = '{a: SRC_Y,   b: SRC_TL,      shift: 7'd64, dst: DST_ACC, add: 1'b1};
      5'd20: o = '{a: SRC_RP2, b: SRC_P11,     shift: 7'd0,  dst: DST_Y,   add: 1'b0};
      5'd21: o = '{a: SRC_Y,   b: SRC_RP,      shift: 7'd33, dst: DST_ACC, add: 1'b1};
      5'd22: o = '{a: SRC_TL,  b: SRC_HUNDRED, shift: 7'd48, dst: DST_TMP, add: 1'b0};
      default: o = '{a: SRC_ONE, b: SRC_ONE, shift: 7'd0, dst: DST_Y, add: 1'b0};
    endcase
    return o;
  endfunction

endpackage

[hdl/bptc_front.sv]
// front end: accepts samples, forms the temperature offset, two-word queue
module bptc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [bptc_pkg::RawW-1:0] raw_temperature_i,
  input  logic [bptc_pkg::RawW-1:0] raw_pressure_i,
  input  logic [15:0]             t1_i,
  output logic                    work_valid_o,
  input  logic                    work_pop_i,
  output bptc_pkg::work_t         work_o
);

  bptc_pkg::work_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  bptc_pkg::work_t wr_word;

  assign full         = (cnt_q == 2'd2);
  assign work_valid_o = (cnt_q != 2'd0);
  assign do_push      = push && !full;
  assign do_pop       = work_pop_i && work_valid_o;
  assign work_o       = mem_q[rd_ptr_q];

  // offset of raw temperature from the calibration point
  always_comb begin
    wr_word.d  = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, t1_i, 8'd0});
    wr_word.rp = raw_pressure_i;
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_word;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[hdl/bptc_engine.sv]
// back end: sequenced multiply and round over a shared 33x33 multiplier
module bptc_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bptc_pkg::CalW-1:0]     cal_i,
  input  logic                          work_valid_i,
  output logic                          work_pop_o,
  input  bptc_pkg::work_t               work_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output bptc_pkg::result_t             res_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_e;

  state_e state_q;
  logic [bptc_pkg::StepW-1:0] step_q;
  logic [2:0]                 phase_q;
  logic signed [24:0]         d_q;
  logic [23:0]                rp_q;
  logic signed [63:0] tl_q, y_q, tsq_q, tcu_q, rp2_q, acc_q, tmp_q;
  logic signed [65:0]  pp_q;
  logic [1:0]          pp_sh_q;
  logic signed [127:0] prod_q;

  bptc_pkg::op_t       op;
  logic signed [63:0]  opa, opb, res, base;
  logic signed [32:0]  a_part, b_part;
  logic signed [127:0] rnd_sum;
  logic [127:0]        half;
  logic signed [63:0]  pres_r;

  // calibration coefficients, little-endian bytes
  logic [15:0] t2, p1, p2, p5, p6, p9;
  logic [7:0]  t3, p3, p4, p7, p8, p10, p11;
  assign t2  = cal_i[31:16];
  assign t3  = cal_i[39:32];
  assign p1  = cal_i[55:40];
  assign p2  = cal_i[71:56];
  assign p3  = cal_i[79:72];
  assign p4  = cal_i[87:80];
  assign p5  = cal_i[103:88];
  assign p6  = cal_i[119:104];
  assign p7  = cal_i[127:120];
  assign p8  = cal_i[135:128];
  assign p9  = cal_i[151:136];
  assign p10 = cal_i[159:152];
  assign p11 = cal_i[167:160];

  assign op = bptc_pkg::op_rom(step_q);

  function automatic logic signed [63:0] src_val(bptc_pkg::src_e s);
    logic signed [63:0] v;
    v = 64'sd0;
    case (s)
      bptc_pkg::SRC_D:       v = 64'(d_q);
      bptc_pkg::SRC_T2S:     v = $signed({30'd0, t2, 18'd0});
      bptc_pkg::SRC_T3:      v = 64'($signed(t3));
      bptc_pkg::SRC_TL:      v = tl_q;
      bptc_pkg::SRC_Y:       v = y_q;
      bptc_pkg::SRC_TSQ:     v = tsq_q;
      bptc_pkg::SRC_TCU:     v = tcu_q;
      bptc_pkg::SRC_RP:      v = $signed({40'd0, rp_q});
      bptc_pkg::SRC_RP2:     v = rp2_q;
      bptc_pkg::SRC_P1S:     v = (64'($signed(p1)) - 64'sd16384) <<< 12;
      bptc_pkg::SRC_P5S:     v = $signed({13'd0, p5, 35'd0});
      bptc_pkg::SRC_ONE:     v = 64'sd1;
      bptc_pkg::SRC_P2M:     v = 64'($signed(p2)) - 64'sd16384;
      bptc_pkg::SRC_P3:      v = 64'($signed(p3));
      bptc_pkg::SRC_P4:      v = 64'($signed(p4));
      bptc_pkg::SRC_P6:      v = $signed({48'd0, p6});
      bptc_pkg::SRC_P7:      v = 64'($signed(p7));
      bptc_pkg::SRC_P8:      v = 64'($signed(p8));
      bptc_pkg::SRC_P9:      v = 64'($signed(p9));
      bptc_pkg::SRC_P10:     v = 64'($signed(p10));
      bptc_pkg::SRC_P11:     v = 64'($signed(p11));
      bptc_pkg::SRC_HUNDRED: v = 64'sd100;
      default:               v = 64'sd0;
    endcase
    return v;
  endfunction

  // operand halves for this partial product
  always_comb begin
    opa    = src_val(op.a);
    opb    = src_val(op.b);
    a_part = phase_q[1] ? {opa[63], opa[63:32]} : {1'b0, opa[31:0]};
    b_part = phase_q[0] ? {opb[63], opb[63:32]} : {1'b0, opb[31:0]};
  end

  // round to nearest, ties up, then arithmetic shift
  always_comb begin
    half    = (op.shift == 7'd0) ? 128'd0 : (128'd1 << (op.shift - 7'd1));
    rnd_sum = (prod_q + $signed(half)) >>> op.shift;
    res     = rnd_sum[63:0];
    case (op.dst)
      bptc_pkg::DST_TL:  base = tl_q;
      bptc_pkg::DST_ACC: base = acc_q;
      default:           base = 64'sd0;
    endcase
  end

  // final scaling and clamps
  always_comb begin
    pres_r = (acc_q + 64'sd33554432) >>> 26;
    res_o.clip = 1'b0;
    if (tmp_q < bptc_pkg::TempMin) begin
      res_o.temp = bptc_pkg::TempW'(bptc_pkg::TempMin);
      res_o.clip = 1'b1;
    end else if (tmp_q > bptc_pkg::TempMax) begin
      res_o.temp = bptc_pkg::TempW'(bptc_pkg::TempMax);
      res_o.clip = 1'b1;
    end else begin
      res_o.temp = tmp_q[bptc_pkg::TempW-1:0];
    end
    if (pres_r < 64'sd0) begin
      res_o.pres = '0;
      res_o.clip = 1'b1;
    end else if (pres_r > bptc_pkg::PresMax) begin
      res_o.pres = bptc_pkg::PresW'(bptc_pkg::PresMax);
      res_o.clip = 1'b1;
    end else begin
      res_o.pres = pres_r[bptc_pkg::PresW-1:0];
    end
  end

  assign work_pop_o  = (state_q == ST_IDLE) && work_valid_i;
  assign res_valid_o = (state_q == ST_FINISH) && res_ready_i;

  // partial product register and product accumulation
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      if (phase_q <= 3'd3) begin
        pp_q    <= a_part * b_part;
        pp_sh_q <= {1'b0, phase_q[1]} + {1'b0, phase_q[0]};
      end
      if (phase_q == 3'd1) begin
        prod_q <= 128'(pp_q) <<< {pp_sh_q, 5'd0};
      end else if (phase_q >= 3'd2 && phase_q <= 3'd4) begin
        prod_q <= prod_q + (128'(pp_q) <<< {pp_sh_q, 5'd0});
      end
    end
  end

  // work registers and write-back
  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      d_q  <= work_i.d;
      rp_q <= work_i.rp;
    end
    if (state_q == ST_RUN && phase_q == 3'd5) begin
      case (op.dst)
        bptc_pkg::DST_TL:  tl_q  <= op.add ? base + res : res;
        bptc_pkg::DST_Y:   y_q   <= res;
        bptc_pkg::DST_TSQ: tsq_q <= res;
        bptc_pkg::DST_TCU: tcu_q <= res;
        bptc_pkg::DST_RP2: rp2_q <= res;
        bptc_pkg::DST_ACC: acc_q <= op.add ? base + res : res;
        bptc_pkg::DST_TMP: tmp_q <= res;
        default:           y_q   <= res;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      phase_q <= 3'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (work_valid_i) begin
            state_q <= ST_RUN;
            step_q  <= '0;
            phase_q <= 3'd0;
          end
        end
        ST_RUN: begin
          if (phase_q == 3'd5) begin
            phase_q <= 3'd0;
            if (step_q == bptc_pkg::LastStep) begin
              state_q <= ST_FINISH;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end else begin
            phase_q <= phase_q + 3'd1;
          end
        end
        ST_FINISH: begin
          if (res_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/baro_pressure_temp_compensation.sv]
// top level: calibration registers, front queue, compute engine, result register
//
//   channel   handshake         payload
//   input     push / full       raw_temperature_i, raw_pressure_i
//   result    empty / pop       temperature_centi_o, pressure_q6_o, clipped_o
//   config    cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// A sample takes 23 multiply steps on one 33x33 multiplier; the engine first takes
// the word from the front queue and at the end hands the result over, and it
// starts a new sample only once the last result has been handed over.
// The front queue holds two samples, so push is taken while the engine works.
// One result register waits for pop; the engine holds its result while full.
// Reset clears the calibration bytes and empties both queues.
module baro_pressure_temp_compensation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [bptc_pkg::RawW-1:0]         raw_temperature_i,
  input  logic [bptc_pkg::RawW-1:0]         raw_pressure_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [bptc_pkg::TempW-1:0] temperature_centi_o,
  output logic [bptc_pkg::PresW-1:0]        pressure_q6_o,
  output logic                              clipped_o,
  input  logic                              cfg_we_i,
  input  logic [bptc_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [bptc_pkg::CfgW-1:0]         cfg_wdata_i
);

  logic [bptc_pkg::CfgW-1:0] cal_lo_q, cal_mid_q;
  logic [bptc_pkg::HiW-1:0]  cal_hi_q;
  logic [bptc_pkg::CalW-1:0] cal;
  logic                      work_valid, work_pop, res_valid, res_ready, out_valid_q;
  bptc_pkg::work_t           work;
  bptc_pkg::result_t         res, out_q;

  assign cal = {cal_hi_q, cal_mid_q, cal_lo_q};

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_lo_q  <= '0;
      cal_mid_q <= '0;
      cal_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bptc_pkg::RegCalLo:  cal_lo_q  <= cfg_wdata_i;
        bptc_pkg::RegCalMid: cal_mid_q <= cfg_wdata_i;
        bptc_pkg::RegCalHi:  cal_hi_q  <= cfg_wdata_i[bptc_pkg::HiW-1:0];
        default: ;
      endcase
    end
  end

  bptc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .t1_i              (cal_lo_q[15:0]),
    .work_valid_o      (work_valid),
    .work_pop_i        (work_pop),
    .work_o            (work)
  );

  bptc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cal_i        (cal),
    .work_valid_i (work_valid),
    .work_pop_o   (work_pop),
    .work_i       (work),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register
  assign res_ready = !out_valid_q || pop;
  assign empty     = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign temperature_centi_o = out_q.temp;
  assign pressure_q6_o       = out_q.pres;
  assign clipped_o           = out_q.clip;

endmodule
